@@ hw/rtl/line_rasterizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// line rasterizer assertion macros
// shared property wrappers, clocked on clock; compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define LR_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("line rasterizer assertion failed");
// checked at every edge, reset included
`define LR_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("line rasterizer reset assertion failed");
`else
`define LR_ASSERT(lbl, prop)
`define LR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ hw/rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg
// shared widths, register indexes and controller/datapath interface types
// ----------------------------------------------------------------------------
package lr_pkg;

   localparam int COORD_W   = 6;
   localparam int COLOR_W   = 24;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_FLAT_COLOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RAISED_COLOR = 2'd1;

   localparam logic [COLOR_W-1:0] FLAT_COLOR_RST   = 24'hffffff;
   localparam logic [COLOR_W-1:0] RAISED_COLOR_RST = 24'he80c0c;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } lr_state_type;

   typedef struct packed {
      logic load;
      logic step;
   } lr_cmd_type;

   typedef struct packed {
      logic last;
   } lr_stat_type;

endpackage

@@ hw/rtl/lr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lr_ctrl
// segment sequencer: takes a segment, then walks the datapath pixel by pixel
// ----------------------------------------------------------------------------
`include "line_rasterizer_core_defines.svh"

module lr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lr_pkg::lr_cmd_type  cmd,
   input  lr_pkg::lr_stat_type stat
);
   import lr_pkg::*;

   lr_state_type state_ff;
   lr_state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RUN);
   assign cmd.load  = (state_ff == ST_IDLE) && req_valid;
   assign cmd.step  = (state_ff == ST_RUN) && !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (!rsp_stall && stat.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LR_ASSERT_ALWAYS(a_reset_no_beat, reset |=> !rsp_valid)
   `LR_ASSERT(a_load_then_pixel, cmd.load |=> rsp_valid)
   `LR_ASSERT(a_last_ends_run, cmd.step && stat.last |=> !rsp_valid && !req_stall)

endmodule

@@ hw/rtl/lr_datapath.sv @@
// ----------------------------------------------------------------------------
// lr_datapath
// colour registers, segment setup and bresenham error-term stepping
// ----------------------------------------------------------------------------
`include "line_rasterizer_core_defines.svh"

module lr_datapath #(
   parameter int CW = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lr_pkg::lr_cmd_type           cmd,
   output lr_pkg::lr_stat_type          stat,
   input  logic                         csr_wr_en,
   input  logic [lr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lr_pkg::COLOR_W-1:0]   csr_wr_data,
   input  logic [lr_pkg::COORD_W-1:0]   req_start_x,
   input  logic [lr_pkg::COORD_W-1:0]   req_start_y,
   input  logic [lr_pkg::COORD_W-1:0]   req_end_x,
   input  logic [lr_pkg::COORD_W-1:0]   req_end_y,
   input  logic                         req_start_raised,
   input  logic                         req_end_raised,
   output logic [lr_pkg::COORD_W-1:0]   rsp_pixel_x,
   output logic [lr_pkg::COORD_W-1:0]   rsp_pixel_y,
   output logic [lr_pkg::COLOR_W-1:0]   rsp_pixel_color,
   output logic                         rsp_last_pixel
);
   import lr_pkg::*;

   localparam int EW = CW + 3;

   logic [COLOR_W-1:0] flat_color_ff, raised_color_ff, line_color_ff;
   logic [CW-1:0]      maj_ff, mnr_ff, maj_end_ff;
   logic [CW-1:0]      maj_in, mnr_in;
   logic [EW-1:0]      err_ff, err_in;
   logic [EW-1:0]      inc_flat_ff, inc_diag_ff;
   logic               minor_neg_ff, steep_ff;

   // setup terms
   logic [CW-1:0] sx, sy, ex, ey, adx, ady;
   logic [CW-1:0] smaj, smin, emaj, emin, dmaj, dmin;
   logic [CW-1:0] maj0, maj1, min0;
   logic          steep, swap, neg;
   logic [EW-1:0] inc_flat, inc_diag, err0;
   logic          err_pos;
   logic          last;

   assign sx = req_start_x[CW-1:0];
   assign sy = req_start_y[CW-1:0];
   assign ex = req_end_x[CW-1:0];
   assign ey = req_end_y[CW-1:0];

   always_comb begin
      adx      = (ex > sx) ? ex - sx : sx - ex;
      ady      = (ey > sy) ? ey - sy : sy - ey;
      steep    = !(ady < adx);
      smaj     = steep ? sy : sx;
      smin     = steep ? sx : sy;
      emaj     = steep ? ey : ex;
      emin     = steep ? ex : ey;
      dmaj     = steep ? ady : adx;
      dmin     = steep ? adx : ady;
      swap     = smaj > emaj;
      maj0     = swap ? emaj : smaj;
      maj1     = swap ? smaj : emaj;
      min0     = swap ? emin : smin;
      neg      = swap ? (smin < emin) : (emin < smin);
      inc_flat = EW'({dmin, 1'b0});
      inc_diag = inc_flat - EW'({dmaj, 1'b0});
      err0     = inc_flat - EW'(dmaj);
   end

   // stepping
   assign err_pos = !err_ff[EW-1] && (err_ff != '0);
   assign last    = (maj_ff == maj_end_ff);

   always_comb begin
      maj_in = maj_ff + 1'b1;
      mnr_in = mnr_ff;
      err_in = err_ff + inc_flat_ff;
      if (err_pos) begin
         err_in = err_ff + inc_diag_ff;
         mnr_in = minor_neg_ff ? mnr_ff - 1'b1 : mnr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flat_color_ff   <= FLAT_COLOR_RST;
         raised_color_ff <= RAISED_COLOR_RST;
      end else if (csr_wr_en) begin
         if (csr_index == REG_FLAT_COLOR)   flat_color_ff   <= csr_wr_data;
         if (csr_index == REG_RAISED_COLOR) raised_color_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         maj_ff        <= '0;
         mnr_ff        <= '0;
         maj_end_ff    <= '0;
         err_ff        <= '0;
         inc_flat_ff   <= '0;
         inc_diag_ff   <= '0;
         minor_neg_ff  <= 1'b0;
         steep_ff      <= 1'b0;
         line_color_ff <= '0;
      end else if (cmd.load) begin
         maj_ff        <= maj0;
         mnr_ff        <= min0;
         maj_end_ff    <= maj1;
         err_ff        <= err0;
         inc_flat_ff   <= inc_flat;
         inc_diag_ff   <= inc_diag;
         minor_neg_ff  <= neg;
         steep_ff      <= steep;
         line_color_ff <= (req_start_raised || req_end_raised) ? raised_color_ff
                                                              : flat_color_ff;
      end else if (cmd.step) begin
         maj_ff <= maj_in;
         mnr_ff <= mnr_in;
         err_ff <= err_in;
      end
   end

   assign stat.last       = last;
   assign rsp_pixel_x     = COORD_W'(steep_ff ? mnr_ff : maj_ff);
   assign rsp_pixel_y     = COORD_W'(steep_ff ? maj_ff : mnr_ff);
   assign rsp_pixel_color = line_color_ff;
   assign rsp_last_pixel  = last;

   `LR_ASSERT(a_major_ascends, cmd.load |=> maj_ff <= maj_end_ff)
   `LR_ASSERT(a_major_unit_step, cmd.step && !last |=> maj_ff == CW'($past(maj_ff) + 1'b1))
   `LR_ASSERT(a_minor_bounded, cmd.step && !last |=> CW'(mnr_ff - $past(mnr_ff) + 1'b1) <= 2)

endmodule

@@ hw/rtl/line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer_core
// bresenham line rasterizer: one segment in, one beat per pixel out
// ----------------------------------------------------------------------------
//   port group  direction  beat contents
//   req_*       in         start_x/y, end_x/y, start_raised, end_raised
//   rsp_*       out        pixel_x/y, pixel_color, last_pixel
//   csr_*       in         0 flat_color, 1 raised_color
//
// a segment of n pixels (n = major span + 1, at most 2**COORD_BITS) is
// accepted and its setup computed and registered; the error-term step unit
// then gives one pixel a cycle while rsp_stall is low
// req_stall stays high from acceptance until the last pixel beat is taken
// synchronous reset returns the sequencer to idle and loads the reset colours
// ----------------------------------------------------------------------------
module line_rasterizer_core #(
   parameter int COORD_BITS = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [lr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lr_pkg::COLOR_W-1:0]   csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lr_pkg::COORD_W-1:0]   req_start_x,
   input  logic [lr_pkg::COORD_W-1:0]   req_start_y,
   input  logic [lr_pkg::COORD_W-1:0]   req_end_x,
   input  logic [lr_pkg::COORD_W-1:0]   req_end_y,
   input  logic                         req_start_raised,
   input  logic                         req_end_raised,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lr_pkg::COORD_W-1:0]   rsp_pixel_x,
   output logic [lr_pkg::COORD_W-1:0]   rsp_pixel_y,
   output logic [lr_pkg::COLOR_W-1:0]   rsp_pixel_color,
   output logic                         rsp_last_pixel
);
   import lr_pkg::*;

   lr_cmd_type  cmd;
   lr_stat_type stat;

   lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   lr_datapath #(
      .CW (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_start_raised (req_start_raised),
      .req_end_raised   (req_end_raised),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_last_pixel   (rsp_last_pixel)
   );

endmodule
